[hdl/hfla_pkg.sv]
// ----------------------------------------------------------------------------
// hfla_pkg: shared definitions of the handle free list allocator
// Handle table geometry, command and status codes, and the record types
// that travel between the sequencer, the table store and the compare unit.
// ----------------------------------------------------------------------------
package hfla_pkg;

  // Number of table entries, entry 0 being the nil handle.
  localparam int HANDLE_COUNT = 128;
  // Width of a table index.
  localparam int IDX_W = $clog2(HANDLE_COUNT);
  // Widths of the request and response fields.
  localparam int HANDLE_W = 7;
  localparam int WORD_W = 32;
  // Longest used-list walk before the list is declared broken.
  localparam int STEP_MAX = HANDLE_COUNT + 2;
  localparam int STEP_W = $clog2(STEP_MAX + 1);

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP  = 2'd2;
  localparam logic [1:0] CMD_OWNER   = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NONE_FREE  = 3'd1;
  localparam logic [2:0] ST_BAD_HANDLE = 3'd2;
  localparam logic [2:0] ST_NOT_IN_USE = 3'd3;
  localparam logic [2:0] ST_NOT_OWNER  = 3'd4;
  localparam logic [2:0] ST_DENIED     = 3'd5;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd6;
  localparam logic [2:0] ST_CORRUPT    = 3'd7;

  // One table entry as read from the store.
  typedef struct packed {
    logic [IDX_W-1:0]  link;
    logic [WORD_W-1:0] owner;
    logic [WORD_W-1:0] tag;
  } entry_t;

  // One write into the store: link and owner/tag are enabled separately.
  typedef struct packed {
    logic              link_en;
    logic              ot_en;
    logic [IDX_W-1:0]  addr;
    logic [IDX_W-1:0]  link;
    logic [WORD_W-1:0] owner;
    logic [WORD_W-1:0] tag;
  } write_t;

  // Values the compare unit checks an entry against.
  typedef struct packed {
    logic [IDX_W-1:0]  target;
    logic [WORD_W-1:0] owner;
    logic [WORD_W-1:0] tag;
  } key_t;

  // Outcome of the compare unit.
  typedef struct packed {
    logic owner_zero;
    logic tag_zero;
    logic owner_eq;
    logic tag_eq;
    logic link_eq;
    logic link_zero;
  } flags_t;

endpackage

[hdl/handle_free_list_allocator_top.sv]
// ----------------------------------------------------------------------------
// handle_free_list_allocator_top: handle allocator with free and used lists
// A sequencer drives one table store and one shared compare unit to
// allocate, release and look up handles, one request at a time.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Fields
//   request   cmd_valid / cmd_stall  command, handle, owner_id, ref_tag, permitted
//   response  rsp_valid / rsp_stall  status, handle_out, ref_out
//
// Allocate, lookup by handle and the simple release cases pass through
// S_ALLOC or S_HCHK and then S_FIN to a response in the output register.
// A release whose handle is not at the used-list head walks the list at
// one entry per cycle through the registered table read port, then pushes
// the handle in S_PUSH. Lookup by owner scans entries 1 to HANDLE_COUNT-1
// at one per cycle.
// Reset is synchronous; it empties the used list and puts every handle on
// the free list at once through valid bits, so no clearing pass is needed.
// A new request is taken while an earlier response still sits in the output
// register; a finished request waits for that register to drain.
module handle_free_list_allocator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic [1:0]                    command,
  input  logic [hfla_pkg::HANDLE_W-1:0] handle,
  input  logic [hfla_pkg::WORD_W-1:0]   owner_id,
  input  logic [hfla_pkg::WORD_W-1:0]   ref_tag,
  input  logic                          permitted,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [2:0]                    status,
  output logic [hfla_pkg::HANDLE_W-1:0] handle_out,
  output logic [hfla_pkg::WORD_W-1:0]   ref_out
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_HCHK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_PUSH  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam logic [hfla_pkg::IDX_W-1:0] LAST_IDX =
    hfla_pkg::IDX_W'(hfla_pkg::HANDLE_COUNT - 1);

  // Control state.
  logic [2:0]                   state, state_next;
  logic [hfla_pkg::IDX_W-1:0]   free_head, free_head_next;
  logic [hfla_pkg::IDX_W-1:0]   used_head, used_head_next;
  logic                         rsp_valid_next;

  // Request copy and sequencer working registers.
  logic [1:0]                    cmd_r, cmd_r_next;
  logic [hfla_pkg::HANDLE_W-1:0] hreq, hreq_next;
  logic [hfla_pkg::WORD_W-1:0]   own_r, own_r_next;
  logic [hfla_pkg::WORD_W-1:0]   tag_r, tag_r_next;
  logic                          perm_r, perm_r_next;
  logic [hfla_pkg::IDX_W-1:0]    prev, prev_next;
  logic [hfla_pkg::IDX_W-1:0]    nxt_r, nxt_r_next;
  logic [hfla_pkg::IDX_W-1:0]    scan_addr, scan_addr_next;
  logic [hfla_pkg::IDX_W-1:0]    chk_addr, chk_addr_next;
  logic [hfla_pkg::STEP_W-1:0]   steps, steps_next;

  // Finished result waiting for the output register.
  logic [2:0]                    fin_status, fin_status_next;
  logic [hfla_pkg::HANDLE_W-1:0] fin_handle, fin_handle_next;
  logic [hfla_pkg::WORD_W-1:0]   fin_tag, fin_tag_next;

  // Output register.
  logic [2:0]                    status_next;
  logic [hfla_pkg::HANDLE_W-1:0] handle_out_next;
  logic [hfla_pkg::WORD_W-1:0]   ref_out_next;

  logic [hfla_pkg::IDX_W-1:0] rd_addr;
  hfla_pkg::write_t           wr;
  hfla_pkg::entry_t           rd;
  hfla_pkg::key_t             key;
  hfla_pkg::flags_t           flags;

  logic                       accept;
  logic [hfla_pkg::IDX_W-1:0] h_idx;
  logic                       h_bad;
  logic                       out_free;

  hfla_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd      (rd)
  );

  hfla_cmp u_cmp (
    .ent   (rd),
    .key   (key),
    .flags (flags)
  );

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // The requested handle as a table index; nil and out-of-range handles are bad.
  assign h_idx = hfla_pkg::IDX_W'(hreq);
  assign h_bad = (hreq == '0) || (32'(hreq) >= 32'(hfla_pkg::HANDLE_COUNT));

  assign key.target = h_idx;
  assign key.owner  = own_r;
  assign key.tag    = tag_r;

  always_comb begin
    state_next      = state;
    free_head_next  = free_head;
    used_head_next  = used_head;
    cmd_r_next      = cmd_r;
    hreq_next       = hreq;
    own_r_next      = own_r;
    tag_r_next      = tag_r;
    perm_r_next     = perm_r;
    prev_next       = prev;
    nxt_r_next      = nxt_r;
    scan_addr_next  = scan_addr;
    chk_addr_next   = chk_addr;
    steps_next      = steps;
    fin_status_next = fin_status;
    fin_handle_next = fin_handle;
    fin_tag_next    = fin_tag;
    status_next     = status;
    handle_out_next = handle_out;
    ref_out_next    = ref_out;
    rsp_valid_next  = rsp_valid && rsp_stall;
    rd_addr         = '0;
    wr              = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_r_next  = command;
          hreq_next   = handle;
          own_r_next  = owner_id;
          tag_r_next  = ref_tag;
          perm_r_next = permitted;
          // Start the first table read in the same cycle the request lands.
          unique case (command)
            hfla_pkg::CMD_ALLOC: begin
              rd_addr    = free_head;
              state_next = S_ALLOC;
            end
            hfla_pkg::CMD_OWNER: begin
              rd_addr        = hfla_pkg::IDX_W'(1);
              chk_addr_next  = hfla_pkg::IDX_W'(1);
              scan_addr_next = hfla_pkg::IDX_W'(2);
              state_next     = S_SCAN;
            end
            default: begin
              rd_addr    = hfla_pkg::IDX_W'(handle);
              state_next = S_HCHK;
            end
          endcase
        end
      end

      S_ALLOC: begin
        // The free-list head entry is on the read port.
        state_next      = S_FIN;
        fin_handle_next = '0;
        fin_tag_next    = '0;
        if ((own_r == '0) || (tag_r == '0)) begin
          fin_status_next = hfla_pkg::ST_DENIED;
        end else if (free_head == '0) begin
          fin_status_next = hfla_pkg::ST_NONE_FREE;
        end else if (!flags.owner_zero || !flags.tag_zero) begin
          fin_status_next = hfla_pkg::ST_CORRUPT;
        end else if (!perm_r) begin
          // A refused allocate writes nothing, which leaves the lists and the
          // entry exactly as they were.
          fin_status_next = hfla_pkg::ST_DENIED;
        end else begin
          wr.link_en      = 1'b1;
          wr.ot_en        = 1'b1;
          wr.addr         = free_head;
          wr.link         = used_head;
          wr.owner        = own_r;
          wr.tag          = tag_r;
          free_head_next  = rd.link;
          used_head_next  = free_head;
          fin_status_next = hfla_pkg::ST_OK;
          fin_handle_next = hfla_pkg::HANDLE_W'(free_head);
          fin_tag_next    = tag_r;
        end
      end

      S_HCHK: begin
        // The requested handle's entry is on the read port.
        state_next      = S_FIN;
        fin_handle_next = '0;
        fin_tag_next    = '0;
        nxt_r_next      = rd.link;
        if (h_bad) begin
          fin_status_next = hfla_pkg::ST_BAD_HANDLE;
        end else if (flags.owner_zero) begin
          fin_status_next = hfla_pkg::ST_NOT_IN_USE;
        end else if (cmd_r == hfla_pkg::CMD_LOOKUP) begin
          fin_status_next = hfla_pkg::ST_OK;
          fin_handle_next = hreq;
          fin_tag_next    = rd.tag;
        end else if (!flags.tag_eq || !flags.owner_eq) begin
          fin_status_next = hfla_pkg::ST_NOT_OWNER;
        end else if (used_head == h_idx) begin
          // Handle at the used-list head: unlink and push in one step.
          used_head_next  = rd.link;
          wr.link_en      = 1'b1;
          wr.ot_en        = 1'b1;
          wr.addr         = h_idx;
          wr.link         = free_head;
          free_head_next  = h_idx;
          fin_status_next = hfla_pkg::ST_OK;
          fin_handle_next = hreq;
        end else if (used_head == '0) begin
          fin_status_next = hfla_pkg::ST_CORRUPT;
        end else begin
          rd_addr    = used_head;
          prev_next  = used_head;
          steps_next = '0;
          state_next = S_WALK;
        end
      end

      S_WALK: begin
        // The entry of prev is on the read port; look for the predecessor.
        if (steps >= hfla_pkg::STEP_W'(hfla_pkg::STEP_MAX)) begin
          fin_status_next = hfla_pkg::ST_CORRUPT;
          fin_handle_next = '0;
          fin_tag_next    = '0;
          state_next      = S_FIN;
        end else if (flags.link_eq) begin
          wr.link_en = 1'b1;
          wr.addr    = prev;
          wr.link    = nxt_r;
          state_next = S_PUSH;
        end else if (flags.link_zero) begin
          fin_status_next = hfla_pkg::ST_CORRUPT;
          fin_handle_next = '0;
          fin_tag_next    = '0;
          state_next      = S_FIN;
        end else begin
          rd_addr    = rd.link;
          prev_next  = rd.link;
          steps_next = steps + 1'b1;
        end
      end

      S_PUSH: begin
        wr.link_en      = 1'b1;
        wr.ot_en        = 1'b1;
        wr.addr         = h_idx;
        wr.link         = free_head;
        free_head_next  = h_idx;
        fin_status_next = hfla_pkg::ST_OK;
        fin_handle_next = hreq;
        fin_tag_next    = '0;
        state_next      = S_FIN;
      end

      S_SCAN: begin
        // The entry of chk_addr is on the read port; the next read goes out.
        if (own_r == '0) begin
          fin_status_next = hfla_pkg::ST_NOT_FOUND;
          fin_handle_next = '0;
          fin_tag_next    = '0;
          state_next      = S_FIN;
        end else if (flags.owner_eq) begin
          fin_status_next = hfla_pkg::ST_OK;
          fin_handle_next = hfla_pkg::HANDLE_W'(chk_addr);
          fin_tag_next    = rd.tag;
          state_next      = S_FIN;
        end else if (chk_addr == LAST_IDX) begin
          fin_status_next = hfla_pkg::ST_NOT_FOUND;
          fin_handle_next = '0;
          fin_tag_next    = '0;
          state_next      = S_FIN;
        end else begin
          rd_addr        = scan_addr;
          chk_addr_next  = scan_addr;
          scan_addr_next = scan_addr + 1'b1;
        end
      end

      S_FIN: begin
        if (out_free) begin
          status_next     = fin_status;
          handle_out_next = fin_handle;
          ref_out_next    = fin_tag;
          rsp_valid_next  = 1'b1;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      free_head <= hfla_pkg::IDX_W'(1);
      used_head <= '0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      free_head <= free_head_next;
      used_head <= used_head_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_r_next;
    hreq       <= hreq_next;
    own_r      <= own_r_next;
    tag_r      <= tag_r_next;
    perm_r     <= perm_r_next;
    prev       <= prev_next;
    nxt_r      <= nxt_r_next;
    scan_addr  <= scan_addr_next;
    chk_addr   <= chk_addr_next;
    steps      <= steps_next;
    fin_status <= fin_status_next;
    fin_handle <= fin_handle_next;
    fin_tag    <= fin_tag_next;
    status     <= status_next;
    handle_out <= handle_out_next;
    ref_out    <= ref_out_next;
  end

endmodule

[hdl/hfla_store.sv]
// ----------------------------------------------------------------------------
// hfla_store: handle table storage
// Link, owner and tag tables with one write port and one registered read
// port. Per-entry valid bits make unwritten entries read as reset values.
// ----------------------------------------------------------------------------
module hfla_store (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [hfla_pkg::IDX_W-1:0]  rd_addr,
  input  hfla_pkg::write_t            wr,
  output hfla_pkg::entry_t            rd
);

  logic [hfla_pkg::IDX_W-1:0]  link_mem  [hfla_pkg::HANDLE_COUNT];
  logic [hfla_pkg::WORD_W-1:0] owner_mem [hfla_pkg::HANDLE_COUNT];
  logic [hfla_pkg::WORD_W-1:0] tag_mem   [hfla_pkg::HANDLE_COUNT];
  logic [hfla_pkg::HANDLE_COUNT-1:0] link_vld;
  logic [hfla_pkg::HANDLE_COUNT-1:0] ot_vld;

  // After reset, entry i links to i+1, and the nil and last entries link to nil.
  function automatic logic [hfla_pkg::IDX_W-1:0] link_init(
    input logic [hfla_pkg::IDX_W-1:0] idx
  );
    logic [hfla_pkg::IDX_W-1:0] val;
    if ((idx == '0) || (idx == hfla_pkg::IDX_W'(hfla_pkg::HANDLE_COUNT - 1))) begin
      val = '0;
    end else begin
      val = idx + 1'b1;
    end
    return val;
  endfunction

  always_ff @(posedge clk) begin
    if (wr.link_en) begin
      link_mem[wr.addr] <= wr.link;
    end
    if (wr.ot_en) begin
      owner_mem[wr.addr] <= wr.owner;
      tag_mem[wr.addr]   <= wr.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
      ot_vld   <= '0;
    end else begin
      if (wr.link_en) begin
        link_vld[wr.addr] <= 1'b1;
      end
      if (wr.ot_en) begin
        ot_vld[wr.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd.link  <= link_vld[rd_addr] ? link_mem[rd_addr] : link_init(rd_addr);
    rd.owner <= ot_vld[rd_addr] ? owner_mem[rd_addr] : '0;
    rd.tag   <= ot_vld[rd_addr] ? tag_mem[rd_addr] : '0;
  end

endmodule

[hdl/hfla_cmp.sv]
// ----------------------------------------------------------------------------
// hfla_cmp: shared entry compare unit
// Checks the entry just read against the request's owner, tag and target
// handle; used by the allocate, release, walk and scan steps alike.
// ----------------------------------------------------------------------------
module hfla_cmp (
  input  hfla_pkg::entry_t ent,
  input  hfla_pkg::key_t   key,
  output hfla_pkg::flags_t flags
);

  always_comb begin
    flags.owner_zero = (ent.owner == '0);
    flags.tag_zero   = (ent.tag == '0);
    flags.owner_eq   = (ent.owner == key.owner);
    flags.tag_eq     = (ent.tag == key.tag);
    flags.link_eq    = (ent.link == key.target);
    flags.link_zero  = (ent.link == '0);
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the handle free list allocator
// Drives allocate, release and both lookups over the request channel, keeps
// its own copy of the handle table with its free and used lists, and checks
// every response in order against that copy. A short table of hand-picked
// requests comes first, then three random phases with varying idle patterns.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HANDLE_COUNT = hfla_pkg::HANDLE_COUNT;
  localparam int HANDLE_W = hfla_pkg::HANDLE_W;
  localparam int WORD_W = hfla_pkg::WORD_W;

  localparam int CLK_PERIOD = 10;
  // Cycles without any accepted request or response before the run is abandoned.
  // The slowest request walks the whole used list, so this leaves ample margin.
  localparam int IDLE_LIMIT = 5000;
  // Quiet time after the last response, long enough for a full list walk.
  localparam int DRAIN_CYCLES = 2 * HANDLE_COUNT + 40;
  localparam int PHASE_ITEMS = 235;
  localparam int OWNER_POOL = 8;

  // One response as the allocator reports it.
  typedef struct packed {
    logic [2:0]          status;
    logic [HANDLE_W-1:0] handle;
    logic [WORD_W-1:0]   tag;
  } response_t;

  // One request, plus an optional response written into the table by hand.
  // When typed is low, the expected response comes from the table model.
  typedef struct packed {
    logic [1:0]          cmd;
    logic [HANDLE_W-1:0] handle;
    logic [WORD_W-1:0]   owner;
    logic [WORD_W-1:0]   tag;
    logic                permitted;
    logic                typed;
    response_t           want;
  } request_t;

  // Hand-picked opening sequence. Right after reset the free list runs 1, 2, 3
  // and so on, so the first granted allocate must return handle 1. A refused
  // allocate puts its handle straight back on the free head, so the next one
  // gets the same handle again. The release of handle 1 while the used list
  // reads 3, 2, 1 forces a walk down to the tail, while the release of handle
  // 3 takes the used-list head directly. The owner lookup for owner 1 must
  // report handle 2, the lowest match, though handle 3 sits nearer the head.
  localparam int DIRECTED_N = 23;
  localparam request_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{hfla_pkg::CMD_LOOKUP,  7'd0,   32'd0,         32'd0,         1'b0, 1'b1,
      '{hfla_pkg::ST_BAD_HANDLE, 7'd0, 32'd0}},
    '{hfla_pkg::CMD_LOOKUP,  7'd127, 32'd0,         32'd0,         1'b0, 1'b1,
      '{hfla_pkg::ST_NOT_IN_USE, 7'd0, 32'd0}},
    '{hfla_pkg::CMD_OWNER,   7'd0,   32'd0,         32'd0,         1'b0, 1'b1,
      '{hfla_pkg::ST_NOT_FOUND, 7'd0, 32'd0}},
    '{hfla_pkg::CMD_OWNER,   7'd0,   32'hFFFF_FFFF, 32'd0,         1'b0, 1'b1,
      '{hfla_pkg::ST_NOT_FOUND, 7'd0, 32'd0}},
    '{hfla_pkg::CMD_RELEASE, 7'd5,   32'd1,         32'd1,         1'b1, 1'b1,
      '{hfla_pkg::ST_NOT_IN_USE, 7'd0, 32'd0}},
    '{hfla_pkg::CMD_RELEASE, 7'd0,   32'd1,         32'd1,         1'b1, 1'b1,
      '{hfla_pkg::ST_BAD_HANDLE, 7'd0, 32'd0}},
    '{hfla_pkg::CMD_ALLOC,   7'd0,   32'd0,         32'd1,         1'b1, 1'b1,
      '{hfla_pkg::ST_DENIED, 7'd0, 32'd0}},
    '{hfla_pkg::CMD_ALLOC,   7'd0,   32'd1,         32'd0,         1'b1, 1'b1,
      '{hfla_pkg::ST_DENIED, 7'd0, 32'd0}},
    '{hfla_pkg::CMD_ALLOC,   7'd0,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
      '{hfla_pkg::ST_OK, 7'd1, 32'hFFFF_FFFF}},
    '{hfla_pkg::CMD_ALLOC,   7'd0,   32'd1,         32'd1,         1'b0, 1'b1,
      '{hfla_pkg::ST_DENIED, 7'd0, 32'd0}},
    '{hfla_pkg::CMD_ALLOC,   7'd0,   32'd1,         32'd1,         1'b1, 1'b1,
      '{hfla_pkg::ST_OK, 7'd2, 32'd1}},
    '{hfla_pkg::CMD_ALLOC,   7'd0,   32'd1,         32'd2,         1'b1, 1'b1,
      '{hfla_pkg::ST_OK, 7'd3, 32'd2}},
    '{hfla_pkg::CMD_OWNER,   7'd0,   32'd1,         32'd0,         1'b0, 1'b1,
      '{hfla_pkg::ST_OK, 7'd2, 32'd1}},
    '{hfla_pkg::CMD_LOOKUP,  7'd1,   32'd0,         32'd0,         1'b0, 1'b1,
      '{hfla_pkg::ST_OK, 7'd1, 32'hFFFF_FFFF}},
    '{hfla_pkg::CMD_RELEASE, 7'd1,   32'hFFFF_FFFF, 32'd0,         1'b0, 1'b1,
      '{hfla_pkg::ST_NOT_OWNER, 7'd0, 32'd0}},
    '{hfla_pkg::CMD_RELEASE, 7'd1,   32'd1,         32'hFFFF_FFFF, 1'b0, 1'b1,
      '{hfla_pkg::ST_NOT_OWNER, 7'd0, 32'd0}},
    '{hfla_pkg::CMD_RELEASE, 7'd1,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1,
      '{hfla_pkg::ST_OK, 7'd1, 32'd0}},
    '{hfla_pkg::CMD_RELEASE, 7'd3,   32'd1,         32'd2,         1'b0, 1'b1,
      '{hfla_pkg::ST_OK, 7'd3, 32'd0}},
    '{hfla_pkg::CMD_LOOKUP,  7'd3,   32'd0,         32'd0,         1'b0, 1'b1,
      '{hfla_pkg::ST_NOT_IN_USE, 7'd0, 32'd0}},
    '{hfla_pkg::CMD_ALLOC,   7'd0,   32'h8000_0001, 32'h5555_AAAA, 1'b1, 1'b0, '0},
    '{hfla_pkg::CMD_RELEASE, 7'd2,   32'd1,         32'd1,         1'b0, 1'b0, '0},
    '{hfla_pkg::CMD_OWNER,   7'd0,   32'h8000_0001, 32'd0,         1'b0, 1'b0, '0},
    '{hfla_pkg::CMD_LOOKUP,  7'h55,  32'd0,         32'd0,         1'b0, 1'b1,
      '{hfla_pkg::ST_NOT_IN_USE, 7'd0, 32'd0}}
  };

  // Per-phase settings of the random part: idle rates of both sides and the
  // mix of commands. The first phase fills the table until no handle is free,
  // the second drains it again, the third runs a balanced mix at full rate.
  localparam int SEND_IDLE_PCT [3] = '{38, 45, 0};
  localparam int RECV_IDLE_PCT [3] = '{45, 38, 0};
  localparam int ALLOC_PCT [3] = '{88, 20, 40};
  localparam int RELEASE_PCT [3] = '{5, 60, 35};

  logic                clk = 1'b0;
  logic                rst;
  logic                cmd_valid;
  logic                cmd_stall;
  logic [1:0]          command;
  logic [HANDLE_W-1:0] handle;
  logic [WORD_W-1:0]   owner_id;
  logic [WORD_W-1:0]   ref_tag;
  logic                permitted;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic [2:0]          status;
  logic [HANDLE_W-1:0] handle_out;
  logic [WORD_W-1:0]   ref_out;

  // Model of the handle table: one link, owner and tag per entry, plus the
  // heads of the free list and the used list. Entry 0 is the nil handle.
  logic [HANDLE_W-1:0] next_link [HANDLE_COUNT];
  logic [WORD_W-1:0]   owner_of [HANDLE_COUNT];
  logic [WORD_W-1:0]   tag_of [HANDLE_COUNT];
  logic [HANDLE_W-1:0] free_top;
  logic [HANDLE_W-1:0] used_top;

  // Responses still owed by the allocator, oldest first.
  response_t           pending [$];
  logic [WORD_W-1:0]   owner_pool [OWNER_POOL];
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  errors = 0;
  int                  idle_cycles = 0;

  handle_free_list_allocator_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .command    (command),
    .handle     (handle),
    .owner_id   (owner_id),
    .ref_tag    (ref_tag),
    .permitted  (permitted),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .handle_out (handle_out),
    .ref_out    (ref_out)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Put every handle on the free list in ascending order and empty the used list.
  function automatic void clear_tables();
    for (int i = 0; i < HANDLE_COUNT; i++) begin
      owner_of[i] = '0;
      tag_of[i] = '0;
      next_link[i] = (i == 0 || i == HANDLE_COUNT - 1) ? '0 : HANDLE_W'(i + 1);
    end
    free_top = HANDLE_W'(1);
    used_top = '0;
  endfunction

  // Unlink handle h from the used list and push it onto the free list.
  // A broken used list leaves everything untouched and returns 0. The walk
  // is bounded so that a list with a loop in it is caught as well.
  function automatic bit unlink_and_free(input logic [HANDLE_W-1:0] h);
    int unsigned nxt;
    int unsigned prev;
    int          budget;
    nxt = next_link[h];
    if (nxt >= HANDLE_COUNT)
      return 1'b0;
    if (used_top == h) begin
      used_top = HANDLE_W'(nxt);
    end else begin
      prev = used_top;
      budget = HANDLE_COUNT + 2;
      while (prev != 0) begin
        if (prev >= HANDLE_COUNT)
          return 1'b0;
        if (budget <= 0) begin
          prev = 0;
          break;
        end
        budget--;
        if (next_link[prev] == h)
          break;
        prev = next_link[prev];
      end
      if (prev == 0)
        return 1'b0;
      next_link[prev] = HANDLE_W'(nxt);
    end
    next_link[h] = free_top;
    free_top = h;
    owner_of[h] = '0;
    tag_of[h] = '0;
    return 1'b1;
  endfunction

  // Apply one request to the table model and return the response it owes.
  function automatic response_t allocator_outcome(input request_t r);
    response_t           o;
    logic [HANDLE_W-1:0] nh;
    o = '0;
    case (r.cmd)
      hfla_pkg::CMD_ALLOC: begin
        nh = free_top;
        if (r.owner == '0 || r.tag == '0) begin
          o.status = hfla_pkg::ST_DENIED;
        end else if (nh == '0) begin
          o.status = hfla_pkg::ST_NONE_FREE;
        end else if (owner_of[nh] != '0 || tag_of[nh] != '0) begin
          o.status = hfla_pkg::ST_CORRUPT;
        end else begin
          free_top = next_link[nh];
          next_link[nh] = used_top;
          used_top = nh;
          owner_of[nh] = r.owner;
          tag_of[nh] = r.tag;
          if (r.permitted) begin
            o = '{hfla_pkg::ST_OK, nh, r.tag};
          end else begin
            // A refused access check hands the fresh handle straight back.
            void'(unlink_and_free(nh));
            o.status = hfla_pkg::ST_DENIED;
          end
        end
      end
      hfla_pkg::CMD_OWNER: begin
        // Scan downward so that the lowest matching handle wins.
        o.status = hfla_pkg::ST_NOT_FOUND;
        if (r.owner != '0)
          for (int i = HANDLE_COUNT - 1; i >= 1; i--)
            if (owner_of[i] == r.owner)
              o = '{hfla_pkg::ST_OK, HANDLE_W'(i), tag_of[i]};
      end
      default: begin
        if (r.handle == '0 || r.handle >= HANDLE_COUNT) begin
          o.status = hfla_pkg::ST_BAD_HANDLE;
        end else if (owner_of[r.handle] == '0) begin
          o.status = hfla_pkg::ST_NOT_IN_USE;
        end else if (r.cmd == hfla_pkg::CMD_LOOKUP) begin
          o = '{hfla_pkg::ST_OK, r.handle, tag_of[r.handle]};
        end else if (tag_of[r.handle] != r.tag || owner_of[r.handle] != r.owner) begin
          o.status = hfla_pkg::ST_NOT_OWNER;
        end else if (!unlink_and_free(r.handle)) begin
          o.status = hfla_pkg::ST_CORRUPT;
        end else begin
          o = '{hfla_pkg::ST_OK, r.handle, '0};
        end
      end
    endcase
    return o;
  endfunction

  // Owners mostly come from a small pool so that owner lookups find matches,
  // with a few nil owners and fully random ones mixed in.
  function automatic logic [WORD_W-1:0] pick_owner();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3)
      return '0;
    if (roll < 85)
      return owner_pool[$urandom_range(OWNER_POOL - 1)];
    return $urandom();
  endfunction

  // Build one random request. Most releases and lookups name a handle that
  // is live in the model, with its real owner and tag, so that releases get
  // past the checks and walk the used list; now and then a tag bit is flipped.
  // The rest is noise over the whole range of every field.
  function automatic request_t random_request(input int alloc_pct, input int release_pct);
    request_t            r;
    int unsigned         roll;
    logic [HANDLE_W-1:0] busy [$];
    logic [HANDLE_W-1:0] h;
    for (int i = 1; i < HANDLE_COUNT; i++)
      if (owner_of[i] != '0)
        busy.push_back(HANDLE_W'(i));
    r = '0;
    r.handle = HANDLE_W'($urandom_range(HANDLE_COUNT - 1));
    r.owner = pick_owner();
    r.tag = ($urandom_range(99) < 3) ? '0 : $urandom();
    r.permitted = ($urandom_range(99) < 88);
    roll = $urandom_range(99);
    if (roll < alloc_pct)
      r.cmd = hfla_pkg::CMD_ALLOC;
    else if (roll < alloc_pct + release_pct)
      r.cmd = hfla_pkg::CMD_RELEASE;
    else
      r.cmd = roll[0] ? hfla_pkg::CMD_LOOKUP : hfla_pkg::CMD_OWNER;
    if (busy.size() != 0 && $urandom_range(99) < 80) begin
      h = busy[$urandom_range(busy.size() - 1)];
      if (r.cmd == hfla_pkg::CMD_RELEASE || r.cmd == hfla_pkg::CMD_LOOKUP) begin
        r.handle = h;
        r.owner = owner_of[h];
        r.tag = tag_of[h];
        if ($urandom_range(9) == 0)
          r.tag[$urandom_range(WORD_W - 1)] ^= 1'b1;
      end else if (r.cmd == hfla_pkg::CMD_OWNER) begin
        r.owner = owner_of[h];
      end
    end
    return r;
  endfunction

  // Present one request from a falling edge, after a random gap, and hold it
  // until it is accepted. The expected response is worked out at acceptance.
  // Returns at the falling edge after acceptance with valid still high, so the
  // caller either presents the next request or lowers valid before the next
  // rising edge.
  task automatic issue_request(input request_t r);
    response_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid = 1'b0;
      @(negedge clk);
    end
    cmd_valid = 1'b1;
    command = r.cmd;
    handle = r.handle;
    owner_id = r.owner;
    ref_tag = r.tag;
    permitted = r.permitted;
    @(posedge clk);
    while (cmd_stall !== 1'b0)
      @(posedge clk);
    got = allocator_outcome(r);
    pending.push_back(r.typed ? r.want : got);
    @(negedge clk);
  endtask

  // Stop sending and wait for every outstanding response.
  task automatic wait_for_responses();
    cmd_valid = 1'b0;
    while (pending.size() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  // The receiver stalls at random, driven from the falling edge.
  always @(negedge clk)
    rsp_stall <= ($urandom_range(99) < recv_idle_pct);

  // Every accepted response must match the oldest expectation, field by field.
  // A response with nothing expected is a failure of its own.
  always @(posedge clk) begin : check_responses
    response_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected response: status %0d handle %0d tag %h",
                 $time, status, handle_out, ref_out);
        errors++;
      end else begin
        want = pending.pop_front();
        if (status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, status);
          errors++;
        end
        if (handle_out !== want.handle) begin
          $display("%0t: handle_out mismatch: expected %0d, actual %0d",
                   $time, want.handle, handle_out);
          errors++;
        end
        if (ref_out !== want.tag) begin
          $display("%0t: ref_out mismatch: expected %h, actual %h",
                   $time, want.tag, ref_out);
          errors++;
        end
      end
    end
  end

  // Watchdog: a run that stops moving on both channels is a failure.
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    command = hfla_pkg::CMD_ALLOC;
    handle = '0;
    owner_id = '0;
    ref_tag = '0;
    permitted = 1'b0;
    for (int i = 0; i < OWNER_POOL; i++)
      owner_pool[i] = $urandom() | 32'd1;
    clear_tables();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Hand-picked requests, with neither side idling.
    for (int i = 0; i < DIRECTED_N; i++)
      issue_request(DIRECTED_ROWS[i]);

    // Random phases. Each one starts only once every earlier response has
    // come back, so the sender also sits out a full drain of the pipeline.
    for (int p = 0; p < 3; p++) begin
      wait_for_responses();
      send_idle_pct = SEND_IDLE_PCT[p];
      recv_idle_pct = RECV_IDLE_PCT[p];
      repeat (PHASE_ITEMS)
        issue_request(random_request(ALLOC_PCT[p], RELEASE_PCT[p]));
    end

    wait_for_responses();
    recv_idle_pct = 0;
    // Any response beyond the last expected one shows up in this window.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[handle_free_list_allocator_top.f]
hdl/hfla_pkg.sv
hdl/hfla_store.sv
hdl/hfla_cmp.sv
hdl/handle_free_list_allocator_top.sv
tb/testbench.sv
